FILE: sv/tcf_pkg.sv
`timescale 1ns / 1ps

package tcf_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int SCALE_W    = 32;
    localparam int ANGLE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PASS_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PASS_GAIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_STEP_SCALE = CFG_IDX_W'(2);

    localparam logic [GAIN_W-1:0]  LOW_PASS_GAIN_RST   = GAIN_W'(3121);
    localparam logic [GAIN_W-1:0]  HIGH_PASS_GAIN_RST  = GAIN_W'(62415);
    localparam logic [SCALE_W-1:0] GYRO_STEP_SCALE_RST = SCALE_W'(732450);

    // Angle formats
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int GYRO_FRAC       = 40;
    localparam int GSHIFT          = GYRO_FRAC - ANGLE_FRAC_BITS;
    localparam int GAIN_FRAC       = 16;

    // CORDIC datapath
    localparam int CORDIC_PRESHIFT = 14;
    localparam int CORDIC_W        = 34;
    localparam int CACC_W          = 37;
    localparam int CACC_SHIFT      = 32 - ANGLE_FRAC_BITS;
    localparam int STEP_W          = $clog2(CORDIC_STEPS + 1);

    localparam longint PI_Q32_VAL = 64'sd13493037704;
    localparam logic signed [CACC_W-1:0] PI_Q32 = CACC_W'(PI_Q32_VAL);
    localparam logic signed [CACC_W-1:0] CACC_HALF = CACC_W'(1) <<< (CACC_SHIFT - 1);
    localparam logic signed [ANGLE_W-1:0] PI_ANGLE =
        ANGLE_W'((PI_Q32_VAL + (64'sd1 <<< (CACC_SHIFT - 1))) >>> CACC_SHIFT);

    // Shared multiplier and filter datapath
    localparam int OPA_W  = GAIN_W + 2;
    localparam int OPB_W  = 36;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int INC_W  = SAMPLE_W + 1 + SCALE_W;
    localparam int G_W    = ANGLE_W + GSHIFT;
    localparam int GSUM_W = ((G_W > INC_W) ? G_W : INC_W) + 1;
    localparam int D_W    = OPB_W;

    typedef struct packed {
        logic                      busy;
        logic                      done;
        logic signed [ANGLE_W-1:0] angle;
    } tcf_cordic_stat_t;

    // atan(2^-i) in units of 2^-32 rad
    function automatic logic signed [CACC_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [CACC_W-1:0] r;
        unique case (i)
            STEP_W'(0):  r = CACC_W'(64'sd3373259426);
            STEP_W'(1):  r = CACC_W'(64'sd1991351318);
            STEP_W'(2):  r = CACC_W'(64'sd1052175346);
            STEP_W'(3):  r = CACC_W'(64'sd534100635);
            STEP_W'(4):  r = CACC_W'(64'sd268086748);
            STEP_W'(5):  r = CACC_W'(64'sd134174063);
            STEP_W'(6):  r = CACC_W'(64'sd67103403);
            STEP_W'(7):  r = CACC_W'(64'sd33553749);
            STEP_W'(8):  r = CACC_W'(64'sd16777131);
            STEP_W'(9):  r = CACC_W'(64'sd8388597);
            STEP_W'(10): r = CACC_W'(64'sd4194303);
            default:     r = CACC_W'(64'sd1) <<< (32 - int'(i));
        endcase
        return r;
    endfunction

endpackage

FILE: sv/tcf_in_if.sv
`timescale 1ns / 1ps

interface tcf_in_if;
    import tcf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;

    modport source (output valid, output accel_y, output accel_z, output gyro_x, input ready);
    modport sink   (input valid, input accel_y, input accel_z, input gyro_x, output ready);
endinterface

FILE: sv/tcf_out_if.sv
`timescale 1ns / 1ps

interface tcf_out_if;
    import tcf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] accel_angle;
    logic signed [ANGLE_W-1:0] gyro_angle_out;
    logic signed [ANGLE_W-1:0] fused_angle;

    modport source (output valid, output accel_angle, output gyro_angle_out,
                    output fused_angle, input ready);
    modport sink   (input valid, input accel_angle, input gyro_angle_out,
                    input fused_angle, output ready);
endinterface

FILE: sv/tcf_cfg_if.sv
`timescale 1ns / 1ps

interface tcf_cfg_if;
    import tcf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/tcf_cordic.sv
`timescale 1ns / 1ps

module tcf_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tcf_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [tcf_pkg::SAMPLE_W-1:0] accel_z,
    output tcf_pkg::tcf_cordic_stat_t           stat
);
    import tcf_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CACC_W-1:0]   acc_reg;
    logic signed [ANGLE_W-1:0]  angle_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] x0;
    logic signed [CORDIC_W-1:0] y0;
    logic signed [CACC_W-1:0]   step_angle;
    logic                       last_step;
    logic                       z_zero;

    assign xs         = x_reg >>> step_reg;
    assign ys         = y_reg >>> step_reg;
    assign step_angle = atan_step(step_reg);
    assign last_step  = (step_reg == STEP_W'(CORDIC_STEPS));
    assign x0         = CORDIC_W'(accel_y) <<< CORDIC_PRESHIFT;
    assign y0         = CORDIC_W'(accel_z) <<< CORDIC_PRESHIFT;
    assign z_zero     = (accel_z == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                busy_reg <= !z_zero;
                done_reg <= z_zero;
            end
            else if (busy_reg)
            begin
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (z_zero)
            begin
                angle_reg <= (accel_y >= 0) ? '0 : PI_ANGLE;
            end
            // left half plane: turn by pi toward the sign of z first
            if (accel_y < 0)
            begin
                x_reg   <= -x0;
                y_reg   <= -y0;
                acc_reg <= (accel_z > 0) ? PI_Q32 : -PI_Q32;
            end
            else
            begin
                x_reg   <= x0;
                y_reg   <= y0;
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (last_step)
            begin
                angle_reg <= ANGLE_W'((acc_reg + CACC_HALF) >>> CACC_SHIFT);
            end
            else if (y_reg > 0)
            begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                acc_reg <= acc_reg + step_angle;
            end
            else
            begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                acc_reg <= acc_reg - step_angle;
            end
        end
    end

    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;
    assign stat.angle = angle_reg;

endmodule

FILE: sv/tilt_complementary_filter_top.sv
// Each sample passes through the 16-step CORDIC loop (skipped when accel_z is zero) and
// then through the single shared 18x36 multiplier before its result word is registered;
// a new sample is taken only in the idle state, once the previous one is committed.
// A finished word waits in the output register while the next sample is taken.
// Reset: asynchronous, active low; gains and scale return to their defaults, the filter
// state clears and the next sample seeds the gyro angle from the accel angle.
`timescale 1ns / 1ps

module tilt_complementary_filter_top (
    input logic       clk,
    input logic       rst_n,
    tcf_in_if.sink    sample,
    tcf_out_if.source result,
    tcf_cfg_if.sink   cfg
);
    import tcf_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CORDIC = 4'd1;
    localparam logic [3:0] ST_M_INC  = 4'd2;
    localparam logic [3:0] ST_M_LP1  = 4'd3;
    localparam logic [3:0] ST_M_LP2  = 4'd4;
    localparam logic [3:0] ST_ACC    = 4'd5;
    localparam logic [3:0] ST_LOW    = 4'd6;
    localparam logic [3:0] ST_DIFF   = 4'd7;
    localparam logic [3:0] ST_HPD    = 4'd8;
    localparam logic [3:0] ST_M_HP   = 4'd9;
    localparam logic [3:0] ST_HIGH   = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    localparam logic [GAIN_W:0] GAIN_ONE = (GAIN_W + 1)'(1) << GAIN_FRAC;
    localparam logic signed [PROD_W-1:0] GAIN_HALF = PROD_W'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(32'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] S32_MIN = -S32_MAX - PROD_W'(1);
    localparam logic signed [GSUM_W-1:0] GYRO_MAX = (GSUM_W'(1) <<< (G_W - 1)) - GSUM_W'(1);
    localparam logic signed [GSUM_W-1:0] GYRO_MIN = -GYRO_MAX - GSUM_W'(1);
    localparam logic signed [GSUM_W-1:0] GYRO_HALF = GSUM_W'(1) <<< (GSHIFT - 1);

    function automatic logic signed [PROD_W-1:0] round_gain(input logic signed [PROD_W-1:0] x);
        return (x + GAIN_HALF) >>> GAIN_FRAC;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] r;
        priority if (x > S32_MAX)
            r = S32_MAX;
        else if (x < S32_MIN)
            r = S32_MIN;
        else
            r = x;
        return ANGLE_W'(r);
    endfunction

    logic [3:0]  state_reg;
    logic [3:0]  state_next;

    logic [GAIN_W-1:0]  lp_gain_reg;
    logic [GAIN_W-1:0]  hp_gain_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic signed [G_W-1:0]     gyro_reg;
    logic signed [ANGLE_W-1:0] low_reg;
    logic signed [ANGLE_W-1:0] high_reg;
    logic                      first_reg;

    logic signed [SAMPLE_W-1:0] gyro_x_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [GSUM_W-1:0]   inc_reg;
    logic signed [G_W-1:0]      gsat_reg;
    logic signed [G_W-1:0]      gsat_next;
    logic signed [D_W-1:0]      d_reg;
    logic signed [D_W-1:0]      hpd_reg;
    logic signed [ANGLE_W-1:0]  low_new_reg;
    logic signed [ANGLE_W-1:0]  high_new_reg;

    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] accel_angle_reg;
    logic signed [ANGLE_W-1:0] gyro_out_reg;
    logic signed [ANGLE_W-1:0] fused_reg;

    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [GSUM_W-1:0] gsum;
    logic signed [G_W-1:0]    gyro_new;
    logic                     sample_fire;
    logic                     out_free;
    logic                     commit;
    tcf_cordic_stat_t         cst;

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign sample_fire  = sample.valid && sample.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign commit       = (state_reg == ST_OUT) && out_free;

    tcf_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sample_fire),
        .accel_y (sample.accel_y),
        .accel_z (sample.accel_z),
        .stat    (cst)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (sample.valid) state_next = ST_CORDIC;
            ST_CORDIC: if (cst.done) state_next = ST_M_INC;
            ST_M_INC:  state_next = ST_M_LP1;
            ST_M_LP1:  state_next = ST_M_LP2;
            ST_M_LP2:  state_next = ST_ACC;
            ST_ACC:    state_next = ST_LOW;
            ST_LOW:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_HPD;
            ST_HPD:    state_next = ST_M_HP;
            ST_M_HP:   state_next = ST_HIGH;
            ST_HIGH:   state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Shared multiplier operand select; product registered every cycle
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_M_INC:
            begin
                op_a = -OPA_W'(gyro_x_reg);
                op_b = OPB_W'(scale_reg);
            end
            ST_M_LP1:
            begin
                op_a = OPA_W'(lp_gain_reg);
                op_b = OPB_W'(cst.angle);
            end
            ST_M_LP2:
            begin
                op_a = OPA_W'(GAIN_ONE - (GAIN_W + 1)'(lp_gain_reg));
                op_b = OPB_W'(low_reg);
            end
            ST_M_HP:
            begin
                op_a = OPA_W'(hp_gain_reg);
                op_b = hpd_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next = op_a * op_b;
    end

    // Gyro integration with saturation at the output range
    always_comb
    begin
        gsum = GSUM_W'(gyro_reg) + inc_reg;
        priority if (gsum > GYRO_MAX)
            gsat_next = G_W'(GYRO_MAX);
        else if (gsum < GYRO_MIN)
            gsat_next = G_W'(GYRO_MIN);
        else
            gsat_next = G_W'(gsum);
        gyro_new = first_reg ? (G_W'(cst.angle) <<< GSHIFT) : gsat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lp_gain_reg   <= LOW_PASS_GAIN_RST;
            hp_gain_reg   <= HIGH_PASS_GAIN_RST;
            scale_reg     <= GYRO_STEP_SCALE_RST;
            gyro_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_LOW_PASS_GAIN:   lp_gain_reg <= cfg.data[GAIN_W-1:0];
                    CFG_HIGH_PASS_GAIN:  hp_gain_reg <= cfg.data[GAIN_W-1:0];
                    CFG_GYRO_STEP_SCALE: scale_reg   <= cfg.data[SCALE_W-1:0];
                    default:             ;
                endcase
            end
            if (commit)
            begin
                gyro_reg      <= gyro_new;
                low_reg       <= low_new_reg;
                high_reg      <= high_new_reg;
                first_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (sample_fire)
        begin
            gyro_x_reg <= sample.gyro_x;
        end
        unique case (state_reg)
            ST_M_LP1: inc_reg <= GSUM_W'(prod_reg);
            ST_M_LP2: acc_reg <= prod_reg;
            ST_ACC:
            begin
                if (!first_reg)
                begin
                    acc_reg <= acc_reg + prod_reg;
                end
                gsat_reg <= gsat_next;
            end
            ST_LOW:
            begin
                low_new_reg <= sat32(round_gain(acc_reg));
                // increment actually applied after clamping
                inc_reg     <= GSUM_W'(gsat_reg) - GSUM_W'(gyro_reg);
            end
            ST_DIFF: d_reg <= D_W'((inc_reg + GYRO_HALF) >>> GSHIFT);
            ST_HPD:  hpd_reg <= first_reg ? D_W'(cst.angle) : D_W'(high_reg) + d_reg;
            ST_HIGH: high_new_reg <= sat32(round_gain(prod_reg));
            ST_OUT:
            begin
                if (out_free)
                begin
                    accel_angle_reg <= cst.angle;
                    gyro_out_reg    <= ANGLE_W'(gyro_new >>> GSHIFT);
                    fused_reg       <= sat32(PROD_W'(low_new_reg) + PROD_W'(high_new_reg));
                end
            end
            default: ;
        endcase
    end

    assign result.valid          = out_valid_reg;
    assign result.accel_angle    = accel_angle_reg;
    assign result.gyro_angle_out = gyro_out_reg;
    assign result.fused_angle    = fused_reg;

    a_done_in_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        cst.done |-> state_reg == ST_CORDIC)
        else $error("CORDIC finished outside its wait state");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        sample_fire |-> !cst.busy && !cst.done)
        else $error("sample accepted while CORDIC still active");

    a_seed_once: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> !first_reg)
        else $error("seed flag not cleared after a committed word");

    a_word_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result word raised outside the commit step");

endmodule

FILE: verif/tilt_complementary_filter_top_tb.sv
`timescale 1ns / 1ps

module tilt_complementary_filter_top_tb;
    import tcf_pkg::*;

    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     HOLD_AFTER    = 60;
    localparam int     DRAIN_CYCLES  = 40;
    localparam int     MAX_PRINTS    = 100;
    localparam longint PI_RAD_Q32    = 64'sd13493037704;
    localparam logic signed [ANGLE_W-1:0] PI_ROUNDED = 32'sd205887;

    // index 3 is not a register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    // atan(2^-i) in units of 2^-32 rad, i < 12; beyond that 2^(32-i)
    localparam longint ATAN_Q32 [12] = '{
        64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
        64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
        64'sd16777131, 64'sd8388597, 64'sd4194303, 64'sd2097152
    };

    typedef enum int
    {
        RATE_ANY,
        RATE_NEG_FULL,
        RATE_POS_FULL
    } rate_kind_e;

    typedef struct packed
    {
        logic signed [ANGLE_W-1:0] accel_angle;
        logic signed [ANGLE_W-1:0] gyro_angle;
        logic signed [ANGLE_W-1:0] fused_angle;
    } tilt_word_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
        logic signed [SAMPLE_W-1:0] gx;
        logic                       angle_known;
        logic signed [ANGLE_W-1:0]  angle;
    } probe_row_t;

    localparam int PROBE_ROWS = 22;

    // first row seeds the gyro angle after reset
    probe_row_t probe_rows [PROBE_ROWS] = '{
        '{16'sd1000,    16'sd0,       16'sd0,       1'b1, 32'sd0},
        '{16'sd0,       16'sd0,       16'sd1,       1'b1, 32'sd0},
        '{-16'sd1000,   16'sd0,       -16'sd1,      1'b1, PI_ROUNDED},
        '{-16'sd32768,  16'sd0,       16'sd32767,   1'b1, PI_ROUNDED},
        '{16'sd32767,   16'sd0,       -16'sd32768,  1'b1, 32'sd0},
        '{16'sd0,       16'sd32767,   16'sd100,     1'b0, 32'sd0},
        '{16'sd0,       -16'sd32768,  -16'sd100,    1'b0, 32'sd0},
        '{-16'sd32768,  16'sd1,       16'sd0,       1'b0, 32'sd0},
        '{-16'sd32768,  -16'sd1,      16'sd0,       1'b0, 32'sd0},
        '{-16'sd1,      16'sd32767,   16'sd32767,   1'b0, 32'sd0},
        '{-16'sd1,      -16'sd32768,  16'sd32767,   1'b0, 32'sd0},
        '{16'sd32767,   16'sd32767,   -16'sd32768,  1'b0, 32'sd0},
        '{-16'sd32768,  -16'sd32768,  -16'sd32768,  1'b0, 32'sd0},
        '{16'sd32767,   -16'sd32768,  16'sd21845,   1'b0, 32'sd0},
        '{-16'sd32768,  16'sd32767,   -16'sd21846,  1'b0, 32'sd0},
        '{16'sd1,       16'sd1,       16'sd1,       1'b0, 32'sd0},
        '{-16'sd1,      -16'sd1,      -16'sd1,      1'b0, 32'sd0},
        '{16'sd1,       -16'sd1,      16'sd0,       1'b0, 32'sd0},
        '{16'sd16384,   16'sd16384,   16'sd32767,   1'b0, 32'sd0},
        '{-16'sd20000,  16'sd12345,   -16'sd32768,  1'b0, 32'sd0},
        '{16'sd5,       -16'sd3,      16'sd1,       1'b0, 32'sd0},
        '{-16'sd5,      16'sd3,       -16'sd1,      1'b0, 32'sd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet = 1'b0;
    int   cycle_count = 0;
    int   mismatch_count = 0;

    // filter copy
    logic [GAIN_W-1:0]  a1_gain;
    logic [GAIN_W-1:0]  a2_gain;
    logic [SCALE_W-1:0] step_scale;
    longint             gyro_acc;
    longint             low_acc;
    longint             high_acc;
    bit                 seed_pending;

    tilt_word_t pending_words [$];

    tcf_in_if  sample_ch ();
    tcf_out_if result_ch ();
    tcf_cfg_if cfg_ch ();

    tilt_complementary_filter_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint round_asr(input longint x, input int k);
        return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint tilt_atan2(input longint az, input longint ay);
        longint x;
        longint y;
        longint acc;
        longint xs;
        longint ys;
        longint stp;
        int     i;
        x = ay * 16384;
        y = az * 16384;
        acc = 0;
        if (az == 0)
            return (ay >= 0) ? 64'sd0 : round_asr(PI_RAD_Q32, 32 - ANGLE_FRAC_BITS);
        // left half plane: rotate by pi toward the sign of z first
        if (x < 0)
        begin
            acc = (y > 0) ? PI_RAD_Q32 : -PI_RAD_Q32;
            x = -x;
            y = -y;
        end
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            stp = (i < 12) ? ATAN_Q32[i] : (64'sd1 <<< (32 - i));
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                acc = acc + stp;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                acc = acc - stp;
            end
        end
        return round_asr(acc, 32 - ANGLE_FRAC_BITS);
    endfunction

    function automatic tilt_word_t predict_word(input logic signed [SAMPLE_W-1:0] ay,
                                                input logic signed [SAMPLE_W-1:0] az,
                                                input logic signed [SAMPLE_W-1:0] gx);
        tilt_word_t w;
        longint     ang;
        longint     a1;
        longint     a2;
        longint     inc;
        longint     d;
        longint     gmax;
        longint     gmin;
        a1 = longint'(a1_gain);
        a2 = longint'(a2_gain);
        ang = tilt_atan2(longint'(az), longint'(ay));
        gmax = (64'sd1 <<< (31 + GSHIFT)) - 1;
        gmin = -gmax - 1;
        if (seed_pending)
        begin
            gyro_acc = ang <<< GSHIFT;
            low_acc = clamp32(round_asr(a1 * ang, GAIN_FRAC));
            high_acc = clamp32(round_asr(a2 * ang, GAIN_FRAC));
            seed_pending = 1'b0;
        end
        else
        begin
            inc = -longint'(gx) * longint'({32'd0, step_scale});
            // clamp the step so the integral stays in range; high-pass sees the clamped step
            if (inc > 0 && gyro_acc > gmax - inc)
                inc = gmax - gyro_acc;
            else if (inc < 0 && gyro_acc < gmin - inc)
                inc = gmin - gyro_acc;
            gyro_acc = gyro_acc + inc;
            d = round_asr(inc, GSHIFT);
            low_acc = clamp32(round_asr(a1 * ang + (64'sd65536 - a1) * low_acc, GAIN_FRAC));
            high_acc = clamp32(round_asr(a2 * (high_acc + d), GAIN_FRAC));
        end
        w.accel_angle = ang[ANGLE_W-1:0];
        w.gyro_angle = ANGLE_W'(gyro_acc >>> GSHIFT);
        w.fused_angle = ANGLE_W'(clamp32(low_acc + high_acc));
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input logic [ANGLE_W-1:0] got,
                                 input logic [ANGLE_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns mismatch %s: got %0d want %0d", $time, what,
                     $signed(got), $signed(want));
        mismatch_count++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_LOW_PASS_GAIN:   a1_gain = val[GAIN_W-1:0];
            CFG_HIGH_PASS_GAIN:  a2_gain = val[GAIN_W-1:0];
            CFG_GYRO_STEP_SCALE: step_scale = val[SCALE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] a1, input logic [GAIN_W-1:0] a2,
                             input logic [SCALE_W-1:0] scale);
        write_reg(CFG_LOW_PASS_GAIN, CFG_DATA_W'(a1));
        write_reg(CFG_HIGH_PASS_GAIN, CFG_DATA_W'(a2));
        write_reg(CFG_GYRO_STEP_SCALE, scale);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] ay,
                               input logic signed [SAMPLE_W-1:0] az,
                               input logic signed [SAMPLE_W-1:0] gx,
                               input logic angle_known,
                               input logic signed [ANGLE_W-1:0] angle);
        tilt_word_t w;
        int         gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.accel_y <= ay;
        sample_ch.accel_z <= az;
        sample_ch.gyro_x <= gx;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        w = predict_word(ay, az, gx);
        if (angle_known)
            w.accel_angle = angle;
        pending_words.push_back(w);
        @(negedge clk);
    endtask

    task automatic run_phase(input int count, input rate_kind_e kind);
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
        logic signed [SAMPLE_W-1:0] gx;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    ay = SAMPLE_W'($urandom);
                    az = '0;
                end
                1:
                begin
                    ay = SAMPLE_W'($urandom_range(0, 8)) - 16'sd4;
                    az = SAMPLE_W'($urandom_range(0, 8)) - 16'sd4;
                end
                default:
                begin
                    ay = SAMPLE_W'($urandom);
                    az = SAMPLE_W'($urandom);
                end
            endcase
            case (kind)
                RATE_NEG_FULL: gx = -16'sd32768 + SAMPLE_W'($urandom_range(0, 1000));
                RATE_POS_FULL: gx = 16'sd31767 + SAMPLE_W'($urandom_range(0, 1000));
                default:       gx = SAMPLE_W'($urandom);
            endcase
            push_sample(ay, az, gx, 1'b0, '0);
        end
        sample_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic drain;
        while (pending_words.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // result side: random stalls, one long hold-off to back up the input
    initial
    begin : result_side
        int         idle_left;
        int         words_seen;
        bit         hold_done;
        tilt_word_t want;
        idle_left = 0;
        words_seen = 0;
        hold_done = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && words_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (idle_left > 0)
            begin
                idle_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                idle_left = $urandom_range(1, 7) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                words_seen++;
                if (pending_words.size() == 0)
                    flag_mismatch("unexpected word", result_ch.accel_angle, '0);
                else
                begin
                    want = pending_words.pop_front();
                    if (result_ch.accel_angle !== want.accel_angle)
                        flag_mismatch("accel_angle", result_ch.accel_angle, want.accel_angle);
                    if (result_ch.gyro_angle_out !== want.gyro_angle)
                        flag_mismatch("gyro_angle_out", result_ch.gyro_angle_out,
                                      want.gyro_angle);
                    if (result_ch.fused_angle !== want.fused_angle)
                        flag_mismatch("fused_angle", result_ch.fused_angle, want.fused_angle);
                end
            end
        end
    end

    initial
    begin : stimulus
        int r;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.gyro_x = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_LOW_PASS_GAIN;
        cfg_ch.data = '0;
        a1_gain = LOW_PASS_GAIN_RST;
        a2_gain = HIGH_PASS_GAIN_RST;
        step_scale = GYRO_STEP_SCALE_RST;
        gyro_acc = 0;
        low_acc = 0;
        high_acc = 0;
        seed_pending = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows on reset gains
        for (r = 0; r < PROBE_ROWS; r++)
            push_sample(probe_rows[r].ay, probe_rows[r].az, probe_rows[r].gx,
                        probe_rows[r].angle_known, probe_rows[r].angle);
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        drain();

        write_reg(CFG_SPARE, $urandom);
        set_gains(GAIN_W'($urandom), GAIN_W'($urandom), $urandom);
        run_phase(300, RATE_ANY);
        drain();

        // full-scale rates drive the integral into both clamps
        set_gains('0, '1, '1);
        run_phase(300, RATE_NEG_FULL);
        drain();
        set_gains('1, '0, '1);
        run_phase(600, RATE_POS_FULL);
        drain();

        set_gains(16'd32768, 16'd32768, '0);
        run_phase(200, RATE_ANY);
        drain();

        quiet = 1'b1;
        set_gains(GAIN_W'($urandom), GAIN_W'($urandom), $urandom);
        run_phase(250, RATE_ANY);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
